### design/lft_pkg.sv
// shared types and constants for the lowest common ancestor block
`timescale 1ns / 1ps
`default_nettype none

package lft_pkg;

    localparam int MAX_NODES_DEF = 1024;
    localparam int LABEL_W       = 32;
    localparam int COUNT_W       = 11;
    localparam int SLOT_W        = 10;
    localparam int FUNC_W        = 2;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);

    localparam logic [FUNC_W-1:0] FUNC_LOAD_PRE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_IN  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY    = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [SLOT_W-1:0]  slot;
        logic [LABEL_W-1:0] label;
        logic [LABEL_W-1:0] first_node;
        logic [LABEL_W-1:0] second_node;
    } in_item_t;

    typedef struct packed {
        logic [LABEL_W-1:0] ancestor;
        logic               found;
    } out_item_t;

endpackage

`default_nettype wire

### design/lft_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module lft_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### design/lft_cmp.sv
// shared label comparator used by every scan of a query
`timescale 1ns / 1ps
`default_nettype none

module lft_cmp (
    input  wire logic [lft_pkg::LABEL_W-1:0] a,
    input  wire logic [lft_pkg::LABEL_W-1:0] b,
    output      logic                        eq
);

    assign eq = (a == b);

endmodule

`default_nettype wire

### design/lft_ctrl.sv
// query sequencer, count register and output register
`timescale 1ns / 1ps
`default_nettype none

module lft_ctrl #(
    parameter int MAX_NODES = lft_pkg::MAX_NODES_DEF,
    localparam int AW = $clog2(MAX_NODES),
    localparam int CW = $clog2(MAX_NODES + 1)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output      logic                        in_ready,
    input  wire lft_pkg::in_item_t           in_data,
    output      logic                        out_valid,
    input  wire logic                        out_ready,
    output      lft_pkg::out_item_t          out_data,
    input  wire logic                        cfg_we,
    input  wire logic [lft_pkg::COUNT_W-1:0] cfg_wdata,
    output      logic                        pre_we,
    output      logic                        ino_we,
    output      logic [AW-1:0]               waddr,
    output      logic [lft_pkg::LABEL_W-1:0] wdata,
    output      logic                        pre_re,
    output      logic [AW-1:0]               pre_raddr,
    input  wire logic [lft_pkg::LABEL_W-1:0] pre_rdata,
    output      logic                        ino_re,
    output      logic [AW-1:0]               ino_raddr,
    input  wire logic [lft_pkg::LABEL_W-1:0] ino_rdata,
    output      logic [lft_pkg::LABEL_W-1:0] cmp_a,
    output      logic [lft_pkg::LABEL_W-1:0] cmp_b,
    input  wire logic                        cmp_eq
);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_FIND_A  = 6'b000010,
        ST_FIND_B  = 6'b000100,
        ST_PRE_RD  = 6'b001000,
        ST_IN_SCAN = 6'b010000,
        ST_FINISH  = 6'b100000
    } state_t;

    localparam lft_pkg::out_item_t MISS = '{ancestor: '0, found: 1'b0};

    state_t                        state_reg, state_next;
    logic [lft_pkg::COUNT_W-1:0]   count_reg;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic [CW-1:0]                 act_cnt;
    logic [AW-1:0]                 idx_reg, idx_next;
    logic [AW-1:0]                 p_reg, p_next;
    logic [AW-1:0]                 pos_a_reg, pos_a_next;
    logic [AW-1:0]                 lo_reg, lo_next;
    logic [AW-1:0]                 hi_reg, hi_next;
    logic [lft_pkg::LABEL_W-1:0]   na_reg, na_next;
    logic [lft_pkg::LABEL_W-1:0]   nb_reg, nb_next;
    lft_pkg::out_item_t            res_reg, res_next;
    lft_pkg::out_item_t            out_reg, out_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          xfer;
    logic                          slot_ok;
    logic                          idx_last;
    logic                          p_last;

    // a count above the table depth acts as the depth
    assign act_cnt = (32'(count_reg) > MAX_NODES) ? CW'(MAX_NODES) : CW'(count_reg);

    assign in_ready  = (state_reg == ST_IDLE);
    assign xfer      = in_valid && in_ready;
    assign slot_ok   = (32'(in_data.slot) < MAX_NODES);
    assign pre_we    = xfer && (in_data.func == lft_pkg::FUNC_LOAD_PRE) && slot_ok;
    assign ino_we    = xfer && (in_data.func == lft_pkg::FUNC_LOAD_IN) && slot_ok;
    assign waddr     = AW'(in_data.slot);
    assign wdata     = in_data.label;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign idx_last = ((CW'(idx_reg) + CW'(1)) == cnt_reg);
    assign p_last   = ((CW'(p_reg) + CW'(1)) == cnt_reg);

    assign cmp_a = ino_rdata;

    always_comb
    begin
        case (state_reg)
            ST_FIND_A: cmp_b = na_reg;
            ST_FIND_B: cmp_b = nb_reg;
            default:   cmp_b = pre_rdata;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        p_next         = p_reg;
        pos_a_next     = pos_a_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        na_next        = na_reg;
        nb_next        = nb_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        pre_re         = 1'b0;
        pre_raddr      = p_reg;
        ino_re         = 1'b0;
        ino_raddr      = idx_reg + AW'(1);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (xfer && (in_data.func == lft_pkg::FUNC_QUERY))
                begin
                    na_next  = in_data.first_node;
                    nb_next  = in_data.second_node;
                    cnt_next = act_cnt;
                    if (act_cnt == '0)
                    begin
                        res_next   = MISS;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        ino_re     = 1'b1;
                        ino_raddr  = '0;
                        idx_next   = '0;
                        state_next = ST_FIND_A;
                    end
                end
            end
            ST_FIND_A:
            begin
                if (cmp_eq)
                begin
                    pos_a_next = idx_reg;
                    ino_re     = 1'b1;
                    ino_raddr  = '0;
                    idx_next   = '0;
                    state_next = ST_FIND_B;
                end
                else if (idx_last)
                begin
                    res_next   = MISS;
                    state_next = ST_FINISH;
                end
                else
                begin
                    ino_re   = 1'b1;
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_FIND_B:
            begin
                if (cmp_eq)
                begin
                    lo_next    = (pos_a_reg < idx_reg) ? pos_a_reg : idx_reg;
                    hi_next    = (pos_a_reg < idx_reg) ? idx_reg : pos_a_reg;
                    p_next     = '0;
                    state_next = ST_PRE_RD;
                end
                else if (idx_last)
                begin
                    res_next   = MISS;
                    state_next = ST_FINISH;
                end
                else
                begin
                    ino_re   = 1'b1;
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_PRE_RD:
            begin
                // fetch one preorder label and the start of the inorder range
                pre_re     = 1'b1;
                ino_re     = 1'b1;
                ino_raddr  = lo_reg;
                idx_next   = lo_reg;
                state_next = ST_IN_SCAN;
            end
            ST_IN_SCAN:
            begin
                if (cmp_eq)
                begin
                    res_next   = '{ancestor: pre_rdata, found: 1'b1};
                    state_next = ST_FINISH;
                end
                else if (idx_reg == hi_reg)
                begin
                    if (p_last)
                    begin
                        res_next   = MISS;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        p_next     = p_reg + AW'(1);
                        state_next = ST_PRE_RD;
                    end
                end
                else
                begin
                    ino_re   = 1'b1;
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_FINISH:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= lft_pkg::COUNT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        idx_reg   <= idx_next;
        p_reg     <= p_next;
        pos_a_reg <= pos_a_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        na_reg    <= na_next;
        nb_reg    <= nb_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

endmodule

`default_nettype wire

### design/lca_from_traversals.sv
// load items are taken in the idle state; a query scans the inorder table for each of its
// two labels, then, for each preorder entry read, scans the inorder range between the two
// positions; the worst case is set by the one inorder read port feeding the single shared
// comparator. one item is worked on at a time; the finished result waits in an output
// register while further items are taken.
// reset clears the sequencer, output valid and sets node_count to 1; tables are not cleared
`timescale 1ns / 1ps
`default_nettype none

module lca_from_traversals #(
    parameter int MAX_NODES = lft_pkg::MAX_NODES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output      logic                        in_ready,
    input  wire lft_pkg::in_item_t           in_data,
    output      logic                        out_valid,
    input  wire logic                        out_ready,
    output      lft_pkg::out_item_t          out_data,
    input  wire logic                        cfg_we,
    input  wire logic [lft_pkg::COUNT_W-1:0] cfg_wdata
);

    localparam int AW = $clog2(MAX_NODES);

    logic                        pre_we, ino_we, pre_re, ino_re, cmp_eq;
    logic [AW-1:0]               waddr, pre_raddr, ino_raddr;
    logic [lft_pkg::LABEL_W-1:0] wdata, pre_rdata, ino_rdata, cmp_a, cmp_b;

    lft_ctrl #(
        .MAX_NODES (MAX_NODES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .pre_we    (pre_we),
        .ino_we    (ino_we),
        .waddr     (waddr),
        .wdata     (wdata),
        .pre_re    (pre_re),
        .pre_raddr (pre_raddr),
        .pre_rdata (pre_rdata),
        .ino_re    (ino_re),
        .ino_raddr (ino_raddr),
        .ino_rdata (ino_rdata),
        .cmp_a     (cmp_a),
        .cmp_b     (cmp_b),
        .cmp_eq    (cmp_eq)
    );

    lft_ram #(
        .WIDTH (lft_pkg::LABEL_W),
        .DEPTH (MAX_NODES)
    ) u_pre_ram (
        .clk   (clk),
        .we    (pre_we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (pre_re),
        .raddr (pre_raddr),
        .rdata (pre_rdata)
    );

    lft_ram #(
        .WIDTH (lft_pkg::LABEL_W),
        .DEPTH (MAX_NODES)
    ) u_ino_ram (
        .clk   (clk),
        .we    (ino_we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (ino_re),
        .raddr (ino_raddr),
        .rdata (ino_rdata)
    );

    lft_cmp u_cmp (
        .a  (cmp_a),
        .b  (cmp_b),
        .eq (cmp_eq)
    );

endmodule

`default_nettype wire

### design/lft_chk.sv
// port level checks for the lowest common ancestor block
`timescale 1ns / 1ps
`default_nettype none

module lft_chk (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire lft_pkg::in_item_t  in_data,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire lft_pkg::out_item_t out_data
);

    // a result waiting for its transfer holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // a miss carries a zero ancestor
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.found || out_data.ancestor == '0))
        else $error("missing ancestor is not zero");

    // a query keeps the block busy for at least the next cycle
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.func == lft_pkg::FUNC_QUERY |=> !in_ready)
        else $error("input ready right after a query");

    // load and unused items never raise a result
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.func != lft_pkg::FUNC_QUERY && !out_valid
        |=> !out_valid)
        else $error("result after a non-query transfer");

endmodule

bind lca_from_traversals lft_chk u_lft_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire
